>>> src/interpolated_random_noise_gen_core_defines.svh
// Assertion macros used by the noise generator RTL.
`ifndef INTERPOLATED_RANDOM_NOISE_GEN_CORE_DEFINES_SVH
`define INTERPOLATED_RANDOM_NOISE_GEN_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define IRNG_ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("noise generator check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define IRNG_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("noise generator check failed");

`endif

>>> src/irng_pkg.sv
// Package with field widths and shared types of the noise generator.
package irng_pkg;

  localparam int VOLUME_W  = 15;
  localparam int LENGTH_W  = 16;
  localparam int RANDOM_W  = 16;
  localparam int SAMPLE_W  = 16;
  localparam int TARGET_W  = 17;
  localparam int PRODUCT_W = VOLUME_W + RANDOM_W;

  typedef struct packed {
    logic busy;
    logic done;
  } irng_div_status_t;

endpackage

>>> src/irng_in_if.sv
// Handshake interface that carries one tick word into the noise generator.
interface irng_in_if;
  import irng_pkg::*;

  logic                valid;
  logic                ready;
  logic [VOLUME_W-1:0] volume;
  logic [LENGTH_W-1:0] segment_length;
  logic [RANDOM_W-1:0] random_value;

  modport source (output valid, volume, segment_length, random_value, input ready);
  modport sink (input valid, volume, segment_length, random_value, output ready);
endinterface

>>> src/irng_out_if.sv
// Handshake interface that carries one sample word out of the noise generator.
interface irng_out_if;
  import irng_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

>>> src/irng_div.sv
// Restoring divider that produces one quotient bit per cycle.
module irng_div #(
  parameter int DIVIDEND_W = 33
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [DIVIDEND_W-1:0]           dividend,
  input  logic [irng_pkg::LENGTH_W-1:0]   divisor,
  output logic [DIVIDEND_W-1:0]           quotient,
  output irng_pkg::irng_div_status_t      status
);
  import irng_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo;
  logic [LENGTH_W-1:0]   rem;
  logic [LENGTH_W-1:0]   rem_next;
  logic [LENGTH_W-1:0]   divisor_q;
  logic [CNT_W-1:0]      count;
  logic                  busy;
  logic                  done;
  logic [LENGTH_W:0]     rem_sh;
  logic [LENGTH_W:0]     trial;
  logic                  fits;

  always_comb begin
    rem_sh   = {rem, quo[DIVIDEND_W-1]};
    trial    = rem_sh - {1'b0, divisor_q};
    fits     = ~trial[LENGTH_W];
    rem_next = fits ? trial[LENGTH_W-1:0] : rem_sh[LENGTH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo       <= dividend;
        rem       <= '0;
        divisor_q <= divisor;
        count     <= CNT_W'(DIVIDEND_W);
        busy      <= 1'b1;
      end else if (busy) begin
        quo   <= {quo[DIVIDEND_W-2:0], fits};
        rem   <= rem_next;
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;
endmodule

>>> src/interpolated_random_noise_gen_core.sv
// Linear-interpolated random noise generator: one sample word per tick word.
//
// A tick word on req carries a volume, a segment length and a uniform random
// value; rsp returns one signed Q1.15 sample word for each tick word.
// The sample is the saturated sum of the accumulator and the current slope,
// so it is registered and valid in the cycle after the tick word is accepted.
// A tick that ends a segment draws a new target and starts a new slope.
// The new slope comes from a restoring divider that produces one
// quotient bit per cycle, so such a tick keeps req.ready low through ST_MUL,
// ST_PREP and ST_DIV until the quotient is done; other ticks do not.
// The volume and segment length only matter on ticks that draw.
// Reset clears the accumulator, slope, last target, segment limit and position,
// so the first tick after reset draws a new target.
// The sample is held in an output register; a stalled receiver holds it, and
// a new tick word is taken once that register is free or is read in the same
// cycle.
module interpolated_random_noise_gen_core #(
  parameter int EXTRA_FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  irng_in_if.sink     req,
  irng_out_if.source  rsp
);
  import irng_pkg::*;

  `include "interpolated_random_noise_gen_core_defines.svh"

  localparam int ACC_W   = SAMPLE_W + EXTRA_FRACTION_BITS;
  localparam int DIVW    = TARGET_W + EXTRA_FRACTION_BITS;
  localparam int SLOPE_W = DIVW + 1;
  localparam int SUM_W   = SLOPE_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV
  } state_t;

  state_t                      state;
  logic signed [ACC_W-1:0]     accumulator;
  logic signed [SLOPE_W-1:0]   slope;
  logic signed [TARGET_W-1:0]  last_target;
  logic [LENGTH_W-1:0]         segment_limit;
  logic [LENGTH_W-1:0]         position;
  logic                        out_valid;
  logic signed [SAMPLE_W-1:0]  sample;
  logic [VOLUME_W-1:0]         volume_q;
  logic [RANDOM_W-1:0]         random_q;
  logic [PRODUCT_W-1:0]        product;
  logic                        negative;

  logic                        in_fire;
  logic                        draw;
  logic signed [SUM_W-1:0]     sum;
  logic [SUM_W-ACC_W:0]        sum_top;
  logic signed [ACC_W-1:0]     acc_next;
  logic signed [TARGET_W-1:0]  target;
  logic signed [TARGET_W:0]    diff;
  logic [TARGET_W-1:0]         magnitude;
  logic [DIVW-1:0]             dividend;
  logic [DIVW-1:0]             quotient;
  logic                        div_start;
  irng_div_status_t            div_status;

  assign req.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign in_fire   = req.valid && req.ready;
  assign draw      = position >= segment_limit;

  always_comb begin
    sum     = SUM_W'(accumulator) + SUM_W'(slope);
    sum_top = sum[SUM_W-1:ACC_W-1];
    if ((&sum_top) || !(|sum_top)) begin
      acc_next = sum[ACC_W-1:0];
    end else if (sum[SUM_W-1]) begin
      acc_next = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_next = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  always_comb begin
    target    = $signed({1'b0, product[PRODUCT_W-1:VOLUME_W]})
              - $signed({2'b00, volume_q});
    diff      = (TARGET_W + 1)'(target) - (TARGET_W + 1)'(last_target);
    magnitude = diff[TARGET_W] ? TARGET_W'(-diff) : diff[TARGET_W-1:0];
    dividend  = {magnitude, {EXTRA_FRACTION_BITS{1'b0}}};
    div_start = state == ST_PREP;
  end

  irng_div #(
    .DIVIDEND_W(DIVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (segment_limit),
    .quotient (quotient),
    .status   (div_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      accumulator   <= '0;
      slope         <= '0;
      last_target   <= '0;
      segment_limit <= '0;
      position      <= '0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            accumulator <= acc_next;
            sample      <= acc_next[ACC_W-1 -: SAMPLE_W];
            out_valid   <= 1'b1;
            if (draw) begin
              position      <= LENGTH_W'(1);
              volume_q      <= req.volume;
              random_q      <= req.random_value;
              segment_limit <= (req.segment_length == '0) ? LENGTH_W'(1)
                                                           : req.segment_length;
              state         <= ST_MUL;
            end else begin
              position <= position + 1'b1;
            end
          end
        end
        ST_MUL: begin
          product <= PRODUCT_W'(random_q) * PRODUCT_W'(volume_q);
          state   <= ST_PREP;
        end
        ST_PREP: begin
          last_target <= target;
          negative    <= diff[TARGET_W];
          state       <= ST_DIV;
        end
        ST_DIV: begin
          if (div_status.done) begin
            slope <= negative ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.sample = sample;

  `IRNG_ASSERT_NEXT(a_draw_starts_mul, clk, rst, in_fire && draw, state == ST_MUL)
  `IRNG_ASSERT_SAME(a_done_in_div, clk, rst, div_status.done, state == ST_DIV)
  `IRNG_ASSERT_SAME(a_busy_in_div, clk, rst, div_status.busy, state == ST_DIV)
  `IRNG_ASSERT_SAME(a_position_in_range, clk, rst, state == ST_IDLE,
                    position <= segment_limit)
endmodule

>>> verif/interpolated_random_noise_gen_core_tb.sv
// Self-checking testbench of the noise generator: directed table, then random tick words.
`timescale 1ns / 100ps

module interpolated_random_noise_gen_core_tb;
  import irng_pkg::*;

  localparam int EFB         = 16;
  localparam int ACC_W       = SAMPLE_W + EFB;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_TICKS  = 150;
  localparam int N_DIRECTED  = 22;

  localparam longint ACC_MAX = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
  localparam longint ACC_MIN = -ACC_MAX - 64'sd1;

  typedef struct {
    int vol;
    int len;
    int rnd;
    bit has_exp;
    int exp_sample;
  } tick_row_t;

  logic clk = 1'b0;
  logic rst;

  irng_in_if  req_if ();
  irng_out_if rsp_if ();

  interpolated_random_noise_gen_core #(
    .EXTRA_FRACTION_BITS(EFB)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always #4 clk = ~clk;

  longint noise_acc;
  longint noise_slope;
  longint noise_last_target;
  int     noise_seg_limit;
  int     noise_position;

  logic signed [SAMPLE_W-1:0] expected_samples [$];

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_requests;
  int holds_served;
  int hold_left;
  int ticks_sent;
  int samples_checked;
  int draws_seen;
  int mismatches;

  tick_row_t directed_rows [N_DIRECTED] = '{
    '{32767, 1,     0,     1, 0},
    '{32767, 1,     65535, 1, -32767},
    '{0,     0,     65535, 0, 0},
    '{0,     2,     21845, 1, 0},
    '{32767, 65535, 65535, 1, 0},
    '{32767, 3,     0,     1, 0},
    '{0,     43690, 21845, 0, 0},
    '{21845, 21845, 43690, 0, 0},
    '{16384, 7,     32768, 0, 0},
    '{10922, 4660,  65535, 0, 0},
    '{32767, 0,     0,     0, 0},
    '{1,     65535, 1,     0, 0},
    '{5461,  21845, 43690, 0, 0},
    '{27306, 43690, 21845, 0, 0},
    '{12345, 256,   4096,  0, 0},
    '{32767, 0,     65535, 0, 0},
    '{1,     1,     65535, 0, 0},
    '{1,     4,     0,     0, 0},
    '{32767, 65535, 65535, 0, 0},
    '{0,     0,     0,     0, 0},
    '{21845, 43690, 21845, 0, 0},
    '{32767, 1,     32768, 0, 0}
  };

  function automatic logic signed [SAMPLE_W-1:0] predict_sample(
    input logic [VOLUME_W-1:0] vol,
    input logic [LENGTH_W-1:0] len,
    input logic [RANDOM_W-1:0] rnd
  );
    longint next_acc;
    longint target;
    longint next_shifted;
    begin
      next_acc = noise_acc + noise_slope;
      if (next_acc > ACC_MAX) next_acc = ACC_MAX;
      if (next_acc < ACC_MIN) next_acc = ACC_MIN;
      if (noise_position >= noise_seg_limit) begin
        noise_position = 0;
        target = ((longint'(rnd) * longint'(vol)) >>> 15) - longint'(vol);
        noise_seg_limit = (len == '0) ? 1 : int'(len);
        noise_slope = ((target - noise_last_target) * (64'sd1 <<< EFB))
                      / longint'(noise_seg_limit);
        noise_last_target = target;
        draws_seen++;
      end
      noise_position = (noise_position + 1) & 16'hFFFF;
      noise_acc = next_acc;
      next_shifted = next_acc >>> EFB;
      return next_shifted[SAMPLE_W-1:0];
    end
  endfunction

  task automatic report_mismatch(input string what);
    begin
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    end
  endtask

  task automatic send_tick(
    input logic [VOLUME_W-1:0] vol,
    input logic [LENGTH_W-1:0] len,
    input logic [RANDOM_W-1:0] rnd,
    input bit                  has_exp,
    input logic signed [SAMPLE_W-1:0] exp_sample
  );
    logic signed [SAMPLE_W-1:0] pred;
    begin
      while ($urandom_range(99) < tx_idle_pct) begin
        req_if.valid          <= 1'b0;
        req_if.volume         <= VOLUME_W'($urandom);
        req_if.segment_length <= LENGTH_W'($urandom);
        req_if.random_value   <= RANDOM_W'($urandom);
        @(posedge clk);
      end
      req_if.valid          <= 1'b1;
      req_if.volume         <= vol;
      req_if.segment_length <= len;
      req_if.random_value   <= rnd;
      do @(posedge clk); while (req_if.ready !== 1'b1);
      pred = predict_sample(vol, len, rnd);
      expected_samples.push_back(has_exp ? exp_sample : pred);
      ticks_sent++;
    end
  endtask

  task automatic drain_samples();
    begin
      req_if.valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clk);
    end
  endtask

  task automatic run_random(input int count, input bit with_hold, input bit long_tail);
    logic [VOLUME_W-1:0] vol;
    logic [LENGTH_W-1:0] len;
    logic [RANDOM_W-1:0] rnd;
    int pick;
    begin
      for (int i = 0; i < count; i++) begin
        if (with_hold && i == count / 4) hold_requests++;
        pick = $urandom_range(99);
        vol = (pick < 5) ? '0 : (pick < 10) ? '1 : VOLUME_W'($urandom);
        pick = $urandom_range(99);
        rnd = (pick < 5) ? '0 : (pick < 10) ? '1 : RANDOM_W'($urandom);
        len = LENGTH_W'($urandom);
        if (noise_position >= noise_seg_limit) begin
          pick = $urandom_range(99);
          if (long_tail) len = '1;
          else if (pick < 70) len = LENGTH_W'($urandom_range(3));
          else if (pick < 92) len = LENGTH_W'($urandom_range(32, 4));
          else len = LENGTH_W'($urandom_range(300, 33));
        end
        send_tick(vol, len, rnd, 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("sample word %0d with nothing expected", rsp_if.sample));
      end else begin
        if (rsp_if.sample !== expected_samples[0]) begin
          report_mismatch($sformatf("sample got %0d expected %0d", rsp_if.sample,
                                    expected_samples[0]));
        end
        void'(expected_samples.pop_front());
        samples_checked++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d sample words outstanding", expected_samples.size());
    $display("interpolated_random_noise_gen_core_tb NOT OK");
    $finish;
  end

  initial begin
    noise_acc = 0;
    noise_slope = 0;
    noise_last_target = 0;
    noise_seg_limit = 0;
    noise_position = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_requests = 0;
    holds_served = 0;
    ticks_sent = 0;
    samples_checked = 0;
    draws_seen = 0;
    mismatches = 0;
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.volume <= '0;
    req_if.segment_length <= '0;
    req_if.random_value <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_tick(VOLUME_W'(directed_rows[i].vol), LENGTH_W'(directed_rows[i].len),
                RANDOM_W'(directed_rows[i].rnd), directed_rows[i].has_exp,
                SAMPLE_W'(directed_rows[i].exp_sample));
    end
    drain_samples();

    tx_idle_pct = 14;
    rx_idle_pct = 83;
    run_random(350, 1'b1, 1'b0);
    drain_samples();

    tx_idle_pct = 83;
    rx_idle_pct = 14;
    run_random(350, 1'b0, 1'b0);
    drain_samples();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(350, 1'b1, 1'b0);
    run_random(TAIL_TICKS, 1'b0, 1'b1);

    drain_samples();
    repeat (50) @(posedge clk);

    $display("Sent %0d tick words with %0d segment draws, lengths up to the maximum.",
             ticks_sent, draws_seen);
    $display("Checked %0d sample words under three idling mixes and long receiver stalls.",
             samples_checked);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("interpolated_random_noise_gen_core_tb OK");
    end else begin
      $display("interpolated_random_noise_gen_core_tb NOT OK");
    end
    $finish;
  end

endmodule
